// ===== rtl/psfr_pkg.sv =====
// Shared constants and types of the particle sensor frame receiver.
package psfr_pkg;

  // Field widths of the byte and result words
  localparam int BYTE_W        = 8;
  localparam int VALUE_W       = 16;
  localparam int VALUE_INDEX_W = 4;

  // Frame signature bytes
  localparam logic [BYTE_W-1:0] SIG_FIRST  = 8'h42;
  localparam logic [BYTE_W-1:0] SIG_SECOND = 8'h4D;

  // Frame completion report from the receive logic to the emitter
  typedef struct packed {
    logic valid;
    logic ok;
  } psfr_done_t;

endpackage

// ===== rtl/psfr_if.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
interface psfr_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] data_byte;

  modport source (output valid, output frame_start, output data_byte, input ready);
  modport sink   (input valid, input frame_start, input data_byte, output ready);
endinterface

interface psfr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  value_index;
  logic [15:0] value;
  logic        frame_ok;
  logic        last;

  modport source (output valid, output value_index, output value, output frame_ok,
                  output last, input ready);
  modport sink   (input valid, input value_index, input value, input frame_ok,
                  input last, output ready);
endinterface

// ===== rtl/psfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/psfr_rx.sv =====
// Byte receive logic: frame position, checks, checksum and measurement writes.
module psfr_rx #(
  parameter int MEASUREMENT_COUNT = 12,
  parameter int POS_W             = 6,
  parameter int IDX_W             = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic                       frame_start,
  input  logic [7:0]                 data_byte,
  output logic                       ram_we,
  output logic [IDX_W-1:0]           ram_waddr,
  output logic [15:0]                ram_wdata,
  output psfr_pkg::psfr_done_t       done
);

  localparam int FRAME_LEN  = 2 * MEASUREMENT_COUNT + 8;
  localparam int LEN_FIELD  = 2 * MEASUREMENT_COUNT + 4;
  localparam int MEAS_END   = 4 + 2 * MEASUREMENT_COUNT;
  localparam int SUM_W      = $clog2((FRAME_LEN - 2) * 255 + 1);

  localparam logic [POS_W-1:0] P_FRAME_LEN = POS_W'(FRAME_LEN);
  localparam logic [POS_W-1:0] P_SUM_HI    = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] P_SUM_LO    = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] P_MEAS_BEG  = POS_W'(4);
  localparam logic [POS_W-1:0] P_MEAS_END  = POS_W'(MEAS_END);
  localparam logic [POS_W-1:0] P_SIG1      = POS_W'(0);
  localparam logic [POS_W-1:0] P_SIG2      = POS_W'(1);
  localparam logic [POS_W-1:0] P_LEN_HI    = POS_W'(2);
  localparam logic [POS_W-1:0] P_LEN_LO    = POS_W'(3);
  localparam logic [7:0]       LEN_HI_BYTE = 8'(LEN_FIELD >> 8);
  localparam logic [7:0]       LEN_LO_BYTE = 8'(LEN_FIELD & 255);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             bad_r, bad_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [7:0]       sum_hi_r, sum_hi_nxt;

  logic [POS_W-1:0] pos_eff;
  logic [SUM_W-1:0] sum_base;
  logic             bad_base;
  logic             active;
  logic             meas;
  logic [POS_W-1:0] off;
  logic [POS_W-2:0] pair;
  logic [15:0]      sum16;
  logic             bad_chk;

  // Restart at byte zero on a start flag
  always_comb begin
    pos_eff  = frame_start ? '0 : pos_r;
    sum_base = frame_start ? '0 : sum_r;
    bad_base = frame_start ? 1'b0 : bad_r;
  end

  // Decode the byte position and gather the checks
  always_comb begin
    active  = in_fire && (pos_eff < P_FRAME_LEN);
    meas    = (pos_eff >= P_MEAS_BEG) && (pos_eff < P_MEAS_END);
    off     = pos_eff - P_MEAS_BEG;
    pair    = off[POS_W-1:1];
    sum16   = 16'(sum_base);
    bad_chk = bad_base;
    if (pos_eff == P_SIG1 && data_byte != psfr_pkg::SIG_FIRST) begin
      bad_chk = 1'b1;
    end
    if (pos_eff == P_SIG2 && data_byte != psfr_pkg::SIG_SECOND) begin
      bad_chk = 1'b1;
    end
    if (pos_eff == P_LEN_HI && data_byte != LEN_HI_BYTE) begin
      bad_chk = 1'b1;
    end
    if (pos_eff == P_LEN_LO && data_byte != LEN_LO_BYTE) begin
      bad_chk = 1'b1;
    end
    if (pos_eff == P_SUM_LO &&
        (sum_hi_r != sum16[15:8] || data_byte != sum16[7:0])) begin
      bad_chk = 1'b1;
    end
  end

  // Next state of the frame tracking registers
  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    bad_nxt    = bad_r;
    pend_nxt   = pend_r;
    sum_hi_nxt = sum_hi_r;
    if (active) begin
      pos_nxt = pos_eff + POS_W'(1);
      sum_nxt = (pos_eff < P_SUM_HI) ? sum_base + SUM_W'(data_byte) : sum_base;
      bad_nxt = bad_chk;
      if (meas && !off[0]) begin
        pend_nxt = data_byte;
      end
      if (pos_eff == P_SUM_HI) begin
        sum_hi_nxt = data_byte;
      end
    end
  end

  // On the low byte of each measurement pair, write the whole value to the store
  assign ram_we     = active && meas && off[0];
  assign ram_waddr  = pair[IDX_W-1:0];
  assign ram_wdata  = {pend_r, data_byte};

  // Report the frame outcome on its final byte
  assign done.valid = active && (pos_eff == P_SUM_LO);
  assign done.ok    = !bad_chk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= P_FRAME_LEN;
      sum_r <= '0;
      bad_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      bad_r <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r   <= pend_nxt;
    sum_hi_r <= sum_hi_nxt;
  end

endmodule

// ===== rtl/psfr_emit.sv =====
// Result sequencer: reads the store back and drives the output register.
module psfr_emit #(
  parameter int MEASUREMENT_COUNT = 12,
  parameter int IDX_W             = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psfr_pkg::psfr_done_t done,
  output logic                 busy,
  output logic                 ram_re,
  output logic [IDX_W-1:0]     ram_raddr,
  input  logic [15:0]          ram_rdata,
  psfr_out_if.source           out_if
);

  localparam int VIDX_W = psfr_pkg::VALUE_INDEX_W;
  localparam int VAL_W  = psfr_pkg::VALUE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEASUREMENT_COUNT - 1);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_RD   = 2'd1;
  localparam logic [1:0] E_LD   = 2'd2;
  localparam logic [1:0] E_ERR  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              oval_r, oval_nxt;
  logic [VIDX_W-1:0] oidx_r, oidx_nxt;
  logic [VAL_W-1:0]  oval_data_r, oval_data_nxt;
  logic              ook_r, ook_nxt;
  logic              olast_r, olast_nxt;
  logic              slot_free;

  assign slot_free = !oval_r || out_if.ready;

  // Sequence reads and loads of the output register
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    oval_nxt      = oval_r && !out_if.ready;
    oidx_nxt      = oidx_r;
    oval_data_nxt = oval_data_r;
    ook_nxt       = ook_r;
    olast_nxt     = olast_r;
    ram_re        = 1'b0;
    unique case (state_r)
      E_IDLE: begin
        if (done.valid) begin
          idx_nxt   = '0;
          state_nxt = done.ok ? E_RD : E_ERR;
        end
      end
      E_RD: begin
        ram_re    = 1'b1;
        state_nxt = E_LD;
      end
      E_LD: begin
        if (slot_free) begin
          oval_nxt      = 1'b1;
          oidx_nxt      = VIDX_W'(idx_r);
          oval_data_nxt = ram_rdata;
          ook_nxt       = 1'b1;
          olast_nxt     = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            state_nxt = E_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = E_RD;
          end
        end
      end
      E_ERR: begin
        if (slot_free) begin
          oval_nxt      = 1'b1;
          oidx_nxt      = '0;
          oval_data_nxt = '0;
          ook_nxt       = 1'b0;
          olast_nxt     = 1'b1;
          state_nxt     = E_IDLE;
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != E_IDLE);
  assign ram_raddr = idx_r;

  assign out_if.valid       = oval_r;
  assign out_if.value_index = oidx_r;
  assign out_if.value       = oval_data_r;
  assign out_if.frame_ok    = ook_r;
  assign out_if.last        = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    oidx_r      <= oidx_nxt;
    oval_data_r <= oval_data_nxt;
    ook_r       <= ook_nxt;
    olast_r     <= olast_nxt;
  end

endmodule

// ===== rtl/particle_sensor_frame_receiver_core.sv =====
// Particle sensor frame receiver top level.
//
// in_if carries one sensor byte per word with frame_start on byte 0 of a frame.
// 2*MEASUREMENT_COUNT+8 byte frame: signature, length, values, 2 more, checksum
// out_if carries result words: on a good frame MEASUREMENT_COUNT values in
// index order with last on the final one, on a bad frame one error word.
// While receiving, a byte is taken every cycle. After the final byte the
// sequencer reads the measurement RAM back: each value is read in state E_RD
// and, as the RAM's read data is registered, loaded into the output register
// in state E_LD before the next value is read. in_if.ready stays low until
// the last result of the frame, or the error word of a bad frame, is loaded
// into the output register.
// A stalled out_if holds its word; the sequencer pauses until it is taken.
// Reset returns the block to idle, ignoring bytes until a start flag. The RAM
// is not cleared; every entry is rewritten by a frame before it is read.
module particle_sensor_frame_receiver_core #(
  parameter int MEASUREMENT_COUNT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  psfr_in_if.sink     in_if,
  psfr_out_if.source  out_if
);

  localparam int IDX_W = (MEASUREMENT_COUNT > 1) ? $clog2(MEASUREMENT_COUNT) : 1;
  localparam int POS_W = $clog2(2 * MEASUREMENT_COUNT + 9);

  logic                 in_fire;
  logic                 busy;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [15:0]          ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [15:0]          ram_rdata;
  psfr_pkg::psfr_done_t done;

  // Take bytes only while no frame is being emitted
  assign in_if.ready = !busy;
  assign in_fire     = in_if.valid && !busy;

  psfr_rx #(
    .MEASUREMENT_COUNT (MEASUREMENT_COUNT),
    .POS_W             (POS_W),
    .IDX_W             (IDX_W)
  ) u_rx (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .frame_start (in_if.frame_start),
    .data_byte   (in_if.data_byte),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .done        (done)
  );

  psfr_ram #(
    .WIDTH (psfr_pkg::VALUE_W),
    .DEPTH (MEASUREMENT_COUNT),
    .AW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psfr_emit #(
    .MEASUREMENT_COUNT (MEASUREMENT_COUNT),
    .IDX_W             (IDX_W)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .done      (done),
    .busy      (busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_if    (out_if)
  );

endmodule

// ===== rtl/psfr_checker.sv =====
// Port-level assertions for the frame receiver and their bind to the top level.
module psfr_checker #(
  parameter int MEASUREMENT_COUNT = 12
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_value_index,
  input logic [15:0] out_value,
  input logic        out_frame_ok,
  input logic        out_last
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
                                $stable(out_value_index) && $stable(out_last))
    else $error("result word changed while stalled");

  // An error word is a single zero word marked last
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_ok |-> out_last && out_value == 16'd0 &&
                                   out_value_index == 4'd0)
    else $error("malformed error word");

  // The last good word carries the final index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_ok && out_last |->
      out_value_index == 4'(MEASUREMENT_COUNT - 1))
    else $error("good frame ended at wrong index");

  // No byte is taken while a good frame still has results to send
  a_no_in_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_ok && !out_last |-> !in_ready)
    else $error("input taken during emission");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind particle_sensor_frame_receiver_core psfr_checker #(
  .MEASUREMENT_COUNT (MEASUREMENT_COUNT)
) u_psfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_value_index (out_if.value_index),
  .out_value       (out_if.value),
  .out_frame_ok    (out_if.frame_ok),
  .out_last        (out_if.last)
);
